// File: design/deck_serial_status_link_defines.svh
// ----------------------------------------------------------------------------
// deck serial status link assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef DECK_SERIAL_STATUS_LINK_DEFINES_SVH
`define DECK_SERIAL_STATUS_LINK_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define DSL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define DSL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/dsl_pkg.sv
// ----------------------------------------------------------------------------
// dsl_pkg
// types, codes and constants of the deck serial status link
// ----------------------------------------------------------------------------
package dsl_pkg;

    localparam int FRAME_DEPTH_DEF = 15;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [1:0] OP_RX_BYTE = 2'd0;
    localparam logic [1:0] OP_TICK    = 2'd1;
    localparam logic [1:0] OP_COMMAND = 2'd2;

    localparam logic [2:0] CMD_PLAY   = 3'd0;
    localparam logic [2:0] CMD_RECORD = 3'd1;
    localparam logic [2:0] CMD_FFWD   = 3'd2;
    localparam logic [2:0] CMD_REWIND = 3'd3;
    localparam logic [2:0] CMD_STOP   = 3'd4;

    localparam logic [2:0] EV_NONE        = 3'd0;
    localparam logic [2:0] EV_STATUS      = 3'd1;
    localparam logic [2:0] EV_ACK         = 3'd2;
    localparam logic [2:0] EV_NACK        = 3'd3;
    localparam logic [2:0] EV_BAD_SUM     = 3'd4;
    localparam logic [2:0] EV_UNSUPPORTED = 3'd5;
    localparam logic [2:0] EV_STALL_RESET = 3'd6;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] REG_POLL_PERIOD   = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_STALL_TIMEOUT = 1'b1;

    localparam logic [15:0] POLL_PERIOD_RST   = 16'd200;
    localparam logic [15:0] STALL_TIMEOUT_RST = 16'd1000;

    localparam logic [15:0] CODE_STATUS = 16'h7920;
    localparam logic [15:0] CODE_ACK    = 16'h1001;
    localparam logic [15:0] CODE_NACK   = 16'h1112;

    localparam logic [7:0] POLL_B0  = 8'h61;
    localparam logic [7:0] POLL_B1  = 8'h20;
    localparam logic [7:0] POLL_B2  = 8'h09;
    localparam logic [7:0] POLL_SUM = POLL_B0 + POLL_B1 + POLL_B2;
    localparam logic [7:0] CMD_HDR  = 8'h20;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] rx_byte;
        logic [2:0] command;
    } t_in_item;

    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        tx_last;
        logic        command_taken;
        logic [2:0]  event_res;
        logic [7:0]  nack_code;
        logic        online;
        logic [12:0] status_flags;
    } t_out_item;

    // one classified item waiting for the back end
    typedef struct packed {
        logic [2:0]       ntx;
        logic [3:0][7:0]  tx;
        logic             taken;
        logic [2:0]       ev;
        logic [7:0]       nack;
        logic             online;
        logic [12:0]      flags;
    } t_job;

    function automatic logic [7:0] cmd_code(input logic [2:0] cmd);
        logic [7:0] code;
        unique case (cmd)
            CMD_PLAY:   code = 8'h01;
            CMD_RECORD: code = 8'h02;
            CMD_FFWD:   code = 8'h10;
            CMD_REWIND: code = 8'h20;
            default:    code = 8'h00;
        endcase
        return code;
    endfunction

endpackage

// File: design/dsl_front.sv
// ----------------------------------------------------------------------------
// dsl_front
// accepts items, deframes received bytes, runs the timers and builds jobs
// ----------------------------------------------------------------------------
module dsl_front #(
    parameter int FRAME_DEPTH = dsl_pkg::FRAME_DEPTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_wr_en,
    input  logic [dsl_pkg::CFG_INDEX_W-1:0]       i_cfg_index,
    input  logic [dsl_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  dsl_pkg::t_in_item                     i_in_item,
    output logic                                  o_job_push,
    output dsl_pkg::t_job                         o_job,
    input  logic                                  i_q_full
);
    import dsl_pkg::*;

    localparam int IW = $clog2(FRAME_DEPTH);

    logic [7:0]    r_frame [FRAME_DEPTH];
    logic [IW-1:0] r_index, n_index;
    logic [7:0]    r_sum, n_sum;
    logic [4:0]    r_exp_len, n_exp_len;
    logic          r_await, n_await;
    logic          r_online, n_online;
    logic [12:0]   r_flags, n_flags;
    logic [7:0]    r_last_sum, n_last_sum;
    logic [7:0]    r_last_nack, n_last_nack;
    logic [15:0]   r_since_rx, n_since_rx;
    logic [15:0]   r_since_poll, n_since_poll;
    logic [17:0]   r_since_status, n_since_status;
    logic [15:0]   r_poll_period;
    logic [15:0]   r_stall_timeout;

    logic          w_accept;
    logic [7:0]    w_rx;
    logic          w_first;
    logic [4:0]    w_exp;
    logic          w_is_ck;
    logic [IW:0]   w_idx_inc;
    logic          w_idx_wrap;
    logic [7:0]    w_v0, w_v1, w_v2, w_v3, w_v4, w_v10;
    logic [15:0]   w_code;
    logic [12:0]   w_decoded;
    logic [15:0]   w_rx_inc, w_poll_inc;
    logic [17:0]   w_status_inc, w_three;
    logic          w_stall, w_idle_after, w_poll, w_offline, w_idle;
    logic [7:0]    w_cmd8;
    logic [3:0][7:0] w_tx;
    logic [2:0]    w_ntx;
    logic          w_taken;
    logic [2:0]    w_ev;

    assign w_accept   = i_in_valid && !i_q_full;
    assign o_in_stall = i_q_full;
    assign o_job_push = w_accept;

    // frame view after the current byte is written
    assign w_rx    = i_in_item.rx_byte;
    assign w_v0    = (r_index == IW'(0))  ? w_rx : r_frame[0];
    assign w_v1    = (r_index == IW'(1))  ? w_rx : r_frame[1];
    assign w_v2    = (r_index == IW'(2))  ? w_rx : r_frame[2];
    assign w_v3    = (r_index == IW'(3))  ? w_rx : r_frame[3];
    assign w_v4    = (r_index == IW'(4))  ? w_rx : r_frame[4];
    assign w_v10   = (r_index == IW'(10)) ? w_rx : r_frame[10];
    assign w_code  = {w_v0, w_v1};

    assign w_first    = (r_index == '0);
    assign w_exp      = w_first ? ({1'b0, w_rx[3:0]} + 5'd2) : r_exp_len;
    assign w_is_ck    = (5'(r_index) == w_exp);
    assign w_idx_inc  = {1'b0, r_index} + 1'b1;
    assign w_idx_wrap = (w_idx_inc >= (IW+1)'(FRAME_DEPTH));

    assign w_decoded = {w_v10[4], w_v10[5], w_v4[1], w_v4[2], w_v4[4], w_v3[7],
                        w_v2[0], w_v2[5], w_v3[5], w_v3[3], w_v3[2], w_v3[1], w_v3[0]};

    // saturating millisecond counters
    assign w_rx_inc     = (r_since_rx == 16'hFFFF) ? r_since_rx : r_since_rx + 16'd1;
    assign w_poll_inc   = (r_since_poll == 16'hFFFF) ? r_since_poll : r_since_poll + 16'd1;
    assign w_status_inc = (r_since_status == 18'h3FFFF) ? r_since_status
                                                          : r_since_status + 18'd1;
    assign w_three      = {2'b00, r_poll_period} + {1'b0, r_poll_period, 1'b0};

    assign w_idle       = (r_index == '0) && !r_await;
    assign w_stall      = !w_idle && (w_rx_inc > r_stall_timeout);
    assign w_idle_after = w_stall || w_idle;
    assign w_poll       = w_idle_after && (w_poll_inc > r_poll_period);
    assign w_offline    = (w_status_inc > w_three);
    assign w_cmd8       = cmd_code(i_in_item.command);

    always_comb begin
        n_index        = r_index;
        n_sum          = r_sum;
        n_exp_len      = r_exp_len;
        n_await        = r_await;
        n_online       = r_online;
        n_flags        = r_flags;
        n_last_sum     = r_last_sum;
        n_last_nack    = r_last_nack;
        n_since_rx     = r_since_rx;
        n_since_poll   = r_since_poll;
        n_since_status = r_since_status;
        w_tx           = '0;
        w_ntx          = 3'd0;
        w_taken        = 1'b0;
        w_ev           = EV_NONE;
        unique case (i_in_item.op)
            OP_RX_BYTE: begin
                n_since_rx = '0;
                n_await    = 1'b0;
                if (w_first) begin
                    n_exp_len = w_exp;
                end
                if (w_is_ck) begin
                    n_index = '0;
                    if (r_sum != w_rx) begin
                        w_ev = EV_BAD_SUM;
                    end else if (w_code == CODE_STATUS) begin
                        n_online       = 1'b1;
                        n_since_status = '0;
                        if (r_sum != r_last_sum) begin
                            n_last_sum = r_sum;
                            n_flags    = w_decoded;
                            w_ev       = EV_STATUS;
                        end
                    end else if (w_code == CODE_ACK) begin
                        w_ev = EV_ACK;
                    end else if (w_code == CODE_NACK) begin
                        n_last_nack = w_v2;
                        w_ev        = EV_NACK;
                    end else begin
                        w_ev = EV_UNSUPPORTED;
                    end
                end else begin
                    n_sum   = (w_first ? 8'h00 : r_sum) + w_rx;
                    n_index = w_idx_wrap ? '0 : w_idx_inc[IW-1:0];
                end
            end
            OP_TICK: begin
                n_since_rx     = w_rx_inc;
                n_since_poll   = w_poll_inc;
                n_since_status = w_status_inc;
                if (w_stall) begin
                    n_index = '0;
                    n_await = 1'b0;
                    w_ev    = EV_STALL_RESET;
                end
                if (w_poll) begin
                    w_tx         = {POLL_SUM, POLL_B2, POLL_B1, POLL_B0};
                    w_ntx        = 3'd4;
                    n_since_poll = '0;
                    n_await      = 1'b1;
                end
                if (w_offline) begin
                    n_online = 1'b0;
                end
            end
            OP_COMMAND: begin
                if ((i_in_item.command <= CMD_STOP) && w_idle) begin
                    w_tx    = {8'h00, CMD_HDR + w_cmd8, w_cmd8, CMD_HDR};
                    w_ntx   = 3'd3;
                    n_await = 1'b1;
                    w_taken = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_job.ntx    = w_ntx;
        o_job.tx     = w_tx;
        o_job.taken  = w_taken;
        o_job.ev     = w_ev;
        o_job.nack   = n_last_nack;
        o_job.online = n_online;
        o_job.flags  = n_flags;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < FRAME_DEPTH; i++) begin
                r_frame[i] <= 8'h00;
            end
            r_index         <= '0;
            r_sum           <= '0;
            r_exp_len       <= '0;
            r_await         <= 1'b0;
            r_online        <= 1'b0;
            r_flags         <= '0;
            r_last_sum      <= '0;
            r_last_nack     <= '0;
            r_since_rx      <= '0;
            r_since_poll    <= '0;
            r_since_status  <= '0;
            r_poll_period   <= POLL_PERIOD_RST;
            r_stall_timeout <= STALL_TIMEOUT_RST;
        end else begin
            if (i_cfg_wr_en) begin
                if (i_cfg_index == REG_POLL_PERIOD) begin
                    r_poll_period <= i_cfg_data;
                end
                if (i_cfg_index == REG_STALL_TIMEOUT) begin
                    r_stall_timeout <= i_cfg_data;
                end
            end
            if (w_accept) begin
                if (i_in_item.op == OP_RX_BYTE) begin
                    r_frame[r_index] <= w_rx;
                end
                r_index        <= n_index;
                r_sum          <= n_sum;
                r_exp_len      <= n_exp_len;
                r_await        <= n_await;
                r_online       <= n_online;
                r_flags        <= n_flags;
                r_last_sum     <= n_last_sum;
                r_last_nack    <= n_last_nack;
                r_since_rx     <= n_since_rx;
                r_since_poll   <= n_since_poll;
                r_since_status <= n_since_status;
            end
        end
    end

endmodule

// File: design/dsl_queue.sv
// ----------------------------------------------------------------------------
// dsl_queue
// short job queue between the front and back ends
// ----------------------------------------------------------------------------
module dsl_queue #(
    parameter int DEPTH = dsl_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  dsl_pkg::t_job   i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output dsl_pkg::t_job   o_head
);
    import dsl_pkg::*;

    localparam int PW = $clog2(DEPTH);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [PW:0]   r_count;

    assign o_full  = (r_count == (PW+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: design/dsl_back.sv
// ----------------------------------------------------------------------------
// dsl_back
// expands each job into its result items through an output register
// ----------------------------------------------------------------------------
module dsl_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_valid,
    input  dsl_pkg::t_job       i_job,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output dsl_pkg::t_out_item  o_out_item
);
    import dsl_pkg::*;

    logic       r_out_valid;
    t_out_item  r_out, n_out;
    logic [1:0] r_k;
    logic       w_free, w_load, w_last;
    logic [2:0] w_n;

    assign w_free = !r_out_valid || !i_out_stall;
    assign w_load = i_job_valid && w_free;
    assign w_n    = (i_job.ntx == 3'd0) ? 3'd1 : i_job.ntx;
    assign w_last = ((3'(r_k) + 3'd1) == w_n);
    assign o_pop  = w_load && w_last;

    always_comb begin
        n_out.tx_valid      = (i_job.ntx != 3'd0);
        n_out.tx_byte       = n_out.tx_valid ? i_job.tx[r_k] : 8'h00;
        n_out.tx_last       = w_last;
        n_out.command_taken = i_job.taken;
        n_out.event_res     = i_job.ev;
        n_out.nack_code     = i_job.nack;
        n_out.online        = i_job.online;
        n_out.status_flags  = i_job.flags;
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_k         <= '0;
        end else begin
            if (w_free) begin
                r_out_valid <= i_job_valid;
            end
            if (w_load) begin
                r_k <= w_last ? 2'd0 : r_k + 2'd1;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// File: design/deck_serial_status_link.sv
// ----------------------------------------------------------------------------
// deck_serial_status_link
// controller side of a serial deck-control link with status polling
// ----------------------------------------------------------------------------
// input channel (i_in_valid / o_in_stall) carries one item: a received byte,
// a millisecond tick or a transport command request. every item yields one
// result item, or three or four when it sends a frame (command or status
// poll); one result per byte to send, tx_last marks the final one.
// output channel (o_out_valid / i_out_stall) delivers results from a
// register; an accepted item is written into the job queue, its first
// result is loaded from the queue head into that register, and further
// results follow one per cycle while i_out_stall is low. an item is
// accepted every cycle while the job queue has room; the single result
// port sets the sustained rate, as each item holds it for all its results.
// a stalled receiver holds the current result; the queue fills and
// o_in_stall rises once QUEUE_DEPTH jobs wait.
// synchronous reset clears the frame state, timers, flags and queue and
// loads poll period 200 ms and stall timeout 1000 ms; no clearing pass.
// configuration writes through i_cfg_wr_en take effect at once.
// ----------------------------------------------------------------------------
module deck_serial_status_link #(
    parameter int FRAME_DEPTH = dsl_pkg::FRAME_DEPTH_DEF,
    parameter int QUEUE_DEPTH = dsl_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [dsl_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [dsl_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  dsl_pkg::t_in_item                 i_in_item,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output dsl_pkg::t_out_item                o_out_item
);
    import dsl_pkg::*;

    logic  w_push, w_full, w_pop, w_empty;
    t_job  w_job_in, w_job_head;

    dsl_front #(
        .FRAME_DEPTH (FRAME_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_job_push  (w_push),
        .o_job       (w_job_in),
        .i_q_full    (w_full)
    );

    dsl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_job_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_head  (w_job_head)
    );

    dsl_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (!w_empty),
        .i_job       (w_job_head),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

// File: design/dsl_checker.sv
// ----------------------------------------------------------------------------
// dsl_checker
// port-level checks of the deck serial status link
// ----------------------------------------------------------------------------
`include "deck_serial_status_link_defines.svh"

module dsl_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              o_out_valid,
    input  logic                              i_out_stall,
    input  dsl_pkg::t_out_item                o_out_item
);
    import dsl_pkg::*;

    `DSL_ASSERT_NXT(a_out_hold, i_clk, i_rst_n,
        o_out_valid && i_out_stall,
        o_out_valid && $stable(o_out_item),
        "stalled result item changed")

    `DSL_ASSERT_IMP(a_idle_single, i_clk, i_rst_n,
        o_out_valid && !o_out_item.tx_valid,
        o_out_item.tx_last && (o_out_item.tx_byte == 8'h00) && !o_out_item.command_taken,
        "idle result item is not a lone empty item")

    `DSL_ASSERT_IMP(a_cmd_sends, i_clk, i_rst_n,
        o_out_valid && o_out_item.command_taken,
        o_out_item.tx_valid && (o_out_item.event_res == EV_NONE),
        "taken command without a clean transmit item")

    `DSL_ASSERT_NXT(a_frame_burst, i_clk, i_rst_n,
        o_out_valid && !i_out_stall && !o_out_item.tx_last,
        o_out_valid && o_out_item.tx_valid,
        "transmit frame broken up")

endmodule

bind deck_serial_status_link dsl_checker u_dsl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

// File: tb/deck_serial_status_link_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// deck_serial_status_link_tb
// feeds received bytes, millisecond ticks and transport command requests into
// the link with random valid and stall gaps, keeps a cycle-free model of the
// deframer, poll timer and command path, and checks every result item field
// by field in arrival order
// ----------------------------------------------------------------------------
module deck_serial_status_link_tb;
    import dsl_pkg::*;

    localparam logic [1:0] OP_UNUSED     = 2'd3;
    localparam logic [2:0] CMD_BAD_LAST  = 3'd7;
    localparam int RANDOM_ITEMS = 10;
    localparam int PRINT_LIMIT  = 50;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_cfg_wr_en;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   i_in_valid;
    logic                   o_in_stall;
    t_in_item               i_in_item;
    logic                   o_out_valid;
    logic                   i_out_stall;
    t_out_item              o_out_item;

    deck_serial_status_link dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always #6 i_clk = ~i_clk;

    // link model state
    logic [7:0]  rx_frame [16];
    logic [3:0]  rx_index;
    logic [7:0]  rx_sum;
    logic [4:0]  rx_len;
    logic        reply_pending;
    logic        linked;
    logic [12:0] flags_q;
    logic [7:0]  status_sum_q;
    logic [7:0]  nack_q;
    logic [15:0] rx_quiet_ms;
    logic [15:0] poll_age_ms;
    logic [17:0] status_age_ms;
    logic [15:0] poll_period_cfg;
    logic [15:0] stall_cfg;

    t_out_item  expected_results [$];
    logic [7:0] frame_bytes [$];
    int         mismatches = 0;
    int         items_sent = 0;
    bit         quiet = 1'b1;
    int         hold_req = 0;

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (mismatches < PRINT_LIMIT)
            $display("mismatch: %s got %0h expected %0h at %0t", what, got, want, $time);
        mismatches++;
    endtask

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] transport_code(input logic [2:0] cmd);
        unique case (cmd)
            CMD_PLAY:   return 8'h01;
            CMD_RECORD: return 8'h02;
            CMD_FFWD:   return 8'h10;
            CMD_REWIND: return 8'h20;
            default:    return 8'h00;
        endcase
    endfunction

    function automatic logic [12:0] status_bits_from_frame();
        logic [12:0] f;
        f[0]  = rx_frame[3][0];
        f[1]  = rx_frame[3][1];
        f[2]  = rx_frame[3][2];
        f[3]  = rx_frame[3][3];
        f[4]  = rx_frame[3][5];
        f[5]  = rx_frame[2][5];
        f[6]  = rx_frame[2][0];
        f[7]  = rx_frame[3][7];
        f[8]  = rx_frame[4][4];
        f[9]  = rx_frame[4][2];
        f[10] = rx_frame[4][1];
        f[11] = rx_frame[10][5];
        f[12] = rx_frame[10][4];
        return f;
    endfunction

    task automatic parse_rx_frame(output logic [2:0] ev);
        logic [15:0] code;
        code = {rx_frame[0], rx_frame[1]};
        if (code == CODE_STATUS) begin
            linked = 1'b1;
            status_age_ms = '0;
            if (rx_sum != status_sum_q) begin
                status_sum_q = rx_sum;
                flags_q = status_bits_from_frame();
                ev = EV_STATUS;
            end else begin
                ev = EV_NONE;
            end
        end else if (code == CODE_ACK) begin
            ev = EV_ACK;
        end else if (code == CODE_NACK) begin
            nack_q = rx_frame[2];
            ev = EV_NACK;
        end else begin
            ev = EV_UNSUPPORTED;
        end
    endtask

    task automatic take_rx_byte(input logic [7:0] b, output logic [2:0] ev);
        int idx;
        idx = int'(rx_index);
        ev = EV_NONE;
        rx_frame[idx] = b;
        rx_quiet_ms = '0;
        reply_pending = 1'b0;
        if (idx == 0) begin
            rx_sum = '0;
            rx_len = b[3:0] + 5'd2;
        end
        if (idx == int'(rx_len)) begin
            if (rx_sum == b)
                parse_rx_frame(ev);
            else
                ev = EV_BAD_SUM;
            idx = 0;
        end else begin
            rx_sum = rx_sum + b;
            idx++;
        end
        if (idx >= FRAME_DEPTH_DEF)
            idx = 0;
        rx_index = idx[3:0];
    endtask

    task automatic predict_link(input t_in_item it);
        logic [7:0] tx [4];
        int         ntx;
        int         n;
        int         k;
        logic [2:0] ev;
        logic       taken;
        t_out_item  r;
        ntx = 0;
        ev = EV_NONE;
        taken = 1'b0;
        unique case (it.op)
            OP_RX_BYTE: begin
                take_rx_byte(it.rx_byte, ev);
            end
            OP_TICK: begin
                if (rx_quiet_ms != 16'hFFFF) rx_quiet_ms++;
                if (poll_age_ms != 16'hFFFF) poll_age_ms++;
                if (status_age_ms != 18'h3FFFF) status_age_ms++;
                if ((rx_index != 0 || reply_pending) && rx_quiet_ms > stall_cfg) begin
                    rx_index = '0;
                    reply_pending = 1'b0;
                    ev = EV_STALL_RESET;
                end
                if (rx_index == 0 && !reply_pending && poll_age_ms > poll_period_cfg) begin
                    tx[0] = POLL_B0;
                    tx[1] = POLL_B1;
                    tx[2] = POLL_B2;
                    tx[3] = POLL_B0 + POLL_B1 + POLL_B2;
                    ntx = 4;
                    poll_age_ms = '0;
                    reply_pending = 1'b1;
                end
                if (int'(status_age_ms) > 3 * int'(poll_period_cfg))
                    linked = 1'b0;
            end
            OP_COMMAND: begin
                if (it.command <= CMD_STOP && rx_index == 0 && !reply_pending) begin
                    tx[0] = CMD_HDR;
                    tx[1] = transport_code(it.command);
                    tx[2] = CMD_HDR + tx[1];
                    ntx = 3;
                    reply_pending = 1'b1;
                    taken = 1'b1;
                end
            end
            default: begin
            end
        endcase
        n = (ntx > 0) ? ntx : 1;
        for (k = 0; k < n; k++) begin
            r.tx_valid      = (ntx > 0);
            r.tx_byte       = (ntx > 0) ? tx[k] : 8'h00;
            r.tx_last       = (k == n - 1);
            r.command_taken = taken;
            r.event_res     = ev;
            r.nack_code     = nack_q;
            r.online        = linked;
            r.status_flags  = flags_q;
            expected_results.push_back(r);
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    task automatic send_item(input logic [1:0] op, input logic [7:0] rx, input logic [2:0] cmd);
        t_in_item it;
        int       gap;
        it.op = op;
        it.rx_byte = rx;
        it.command = cmd;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_item <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_link(it);
        if (!(op == OP_UNUSED || (op == OP_COMMAND && cmd > CMD_STOP)))
            items_sent++;
        gap = quiet ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_item(OP_TICK, rand_byte(), 3'($urandom_range(0, 7)));
    endtask

    task automatic send_command(input logic [2:0] cmd);
        send_item(OP_COMMAND, rand_byte(), cmd);
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_item(OP_RX_BYTE, b, 3'($urandom_range(0, 7)));
    endtask

    // frame_bytes followed by its checksum, or a wrong one
    task automatic send_frame(input bit corrupt);
        logic [7:0] sum;
        sum = '0;
        foreach (frame_bytes[i]) begin
            sum = sum + frame_bytes[i];
            send_byte(frame_bytes[i]);
        end
        if (corrupt)
            sum = sum ^ 8'($urandom_range(1, 255));
        send_byte(sum);
    endtask

    task automatic build_status(input logic [7:0] b2, input logic [7:0] b3,
                                input logic [7:0] b4, input logic [7:0] b10);
        frame_bytes.delete();
        frame_bytes.push_back(CODE_STATUS[15:8]);
        frame_bytes.push_back(CODE_STATUS[7:0]);
        frame_bytes.push_back(b2);
        frame_bytes.push_back(b3);
        frame_bytes.push_back(b4);
        repeat (5) frame_bytes.push_back(rand_byte());
        frame_bytes.push_back(b10);
    endtask

    task automatic build_ack();
        frame_bytes.delete();
        frame_bytes.push_back(CODE_ACK[15:8]);
        frame_bytes.push_back(CODE_ACK[7:0]);
    endtask

    task automatic build_nack(input logic [7:0] err);
        frame_bytes.delete();
        frame_bytes.push_back(CODE_NACK[15:8]);
        frame_bytes.push_back(CODE_NACK[7:0]);
        frame_bytes.push_back(err);
    endtask

    // header whose low nibble keeps the checksum inside the frame store
    task automatic build_other();
        logic [3:0] hi;
        logic [3:0] lo;
        hi = 4'($urandom_range(0, 15));
        lo = 4'($urandom_range(0, 12));
        frame_bytes.delete();
        frame_bytes.push_back({hi, lo});
        repeat (int'(lo) + 1) frame_bytes.push_back(rand_byte());
    endtask

    // header with a checksum position past the store: 15 bytes bring the index back to 0
    task automatic send_wrapping_frame();
        logic [3:0] hi;
        logic [3:0] lo;
        hi = 4'($urandom_range(0, 15));
        lo = 4'($urandom_range(13, 15));
        send_byte({hi, lo});
        repeat (FRAME_DEPTH_DEF - 1) send_byte(rand_byte());
    endtask

    task automatic realign();
        if (rx_index != 0)
            send_ticks(int'(stall_cfg) + 1);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
        drain_results();
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (idx == REG_POLL_PERIOD)
            poll_period_cfg = val;
        else
            stall_cfg = val;
    endtask

    // results
    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                flag_mismatch("result with nothing expected", 32'(o_out_item.tx_byte), 0);
            end else begin
                want = expected_results.pop_front();
                if (o_out_item.tx_valid !== want.tx_valid)
                    flag_mismatch("tx_valid", 32'(o_out_item.tx_valid), 32'(want.tx_valid));
                if (o_out_item.tx_byte !== want.tx_byte)
                    flag_mismatch("tx_byte", 32'(o_out_item.tx_byte), 32'(want.tx_byte));
                if (o_out_item.tx_last !== want.tx_last)
                    flag_mismatch("tx_last", 32'(o_out_item.tx_last), 32'(want.tx_last));
                if (o_out_item.command_taken !== want.command_taken)
                    flag_mismatch("command_taken", 32'(o_out_item.command_taken),
                                  32'(want.command_taken));
                if (o_out_item.event_res !== want.event_res)
                    flag_mismatch("event_res", 32'(o_out_item.event_res),
                                  32'(want.event_res));
                if (o_out_item.nack_code !== want.nack_code)
                    flag_mismatch("nack_code", 32'(o_out_item.nack_code),
                                  32'(want.nack_code));
                if (o_out_item.online !== want.online)
                    flag_mismatch("online", 32'(o_out_item.online), 32'(want.online));
                if (o_out_item.status_flags !== want.status_flags)
                    flag_mismatch("status_flags", 32'(o_out_item.status_flags),
                                  32'(want.status_flags));
            end
        end
    end

    // receiver stall
    initial begin : drive_out_stall
        int n;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req != 0) begin
                n = hold_req;
                hold_req = 0;
                i_out_stall <= 1'b1;
                repeat (n) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end else if (!quiet && $urandom_range(0, 99) < 25) begin
                n = pick_gap();
                if (n == 0) n = 1;
                i_out_stall <= 1'b1;
                repeat (n) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic test_reset_values();
        // default poll and stall timers stay quiet over the first ticks
        quiet = 1'b1;
        send_ticks(2);
        drain_results();
    endtask

    task automatic test_commands();
        int c;
        write_reg(REG_POLL_PERIOD, 16'd40);
        write_reg(REG_STALL_TIMEOUT, 16'd30);
        quiet = 1'b0;
        for (c = 0; c <= int'(CMD_BAD_LAST); c++) begin
            send_command(3'(c));
            if (c == int'(CMD_PLAY))
                send_command(CMD_STOP);
            if (c <= int'(CMD_STOP)) begin
                build_ack();
                send_frame(1'b0);
            end
        end
        drain_results();
    endtask

    task automatic test_frames();
        quiet = 1'b0;
        build_status(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_frame(1'b0);
        send_frame(1'b0);
        build_nack(8'hFF);
        send_frame(1'b0);
        build_other();
        send_frame(1'b0);
        build_ack();
        send_frame(1'b1);
        send_wrapping_frame();
        send_item(OP_UNUSED, 8'hFF, CMD_BAD_LAST);
        drain_results();
    endtask

    task automatic test_timing();
        quiet = 1'b0;
        write_reg(REG_POLL_PERIOD, 16'd1);
        write_reg(REG_STALL_TIMEOUT, 16'd1);
        // offline after three poll periods without status
        send_ticks(6);
        send_command(CMD_FFWD);
        send_ticks(3);
        send_command(CMD_REWIND);
        write_reg(REG_STALL_TIMEOUT, 16'd3);
        // partial frame dropped by the receive stall timer
        send_byte(CODE_STATUS[15:8]);
        send_byte(CODE_STATUS[7:0]);
        realign();
        drain_results();
    endtask

    task automatic test_back_pressure();
        int i;
        write_reg(REG_POLL_PERIOD, 16'd1);
        write_reg(REG_STALL_TIMEOUT, 16'd2);
        quiet = 1'b1;
        hold_req = 60;
        for (i = 0; i < 8; i++) begin
            if (i % 4 == 3)
                send_command(3'($urandom_range(0, int'(CMD_STOP))));
            else
                send_ticks(1);
        end
        drain_results();
    endtask

    task automatic test_random();
        int  start;
        int  phase_start;
        int  kind;
        int  n;
        bit  status_in_store;
        start = items_sent;
        phase_start = items_sent - 100;
        status_in_store = 1'b0;
        while (items_sent - start < RANDOM_ITEMS) begin
            if (items_sent - phase_start >= 28) begin
                write_reg(REG_POLL_PERIOD, 16'($urandom_range(1, 6)));
                write_reg(REG_STALL_TIMEOUT, 16'($urandom_range(1, 8)));
                quiet = ($urandom_range(0, 3) == 0);
                phase_start = items_sent;
            end
            kind = $urandom_range(0, 99);
            if (kind < 72) realign();
            if (kind < 30) begin
                if (!(status_in_store && $urandom_range(0, 3) == 0))
                    build_status(rand_byte(), rand_byte(), rand_byte(), rand_byte());
                send_frame(1'b0);
                status_in_store = 1'b1;
            end else begin
                status_in_store = 1'b0;
                if (kind < 40) begin
                    build_ack();
                    send_frame(1'b0);
                end else if (kind < 50) begin
                    build_nack(rand_byte());
                    send_frame(1'b0);
                end else if (kind < 57) begin
                    build_other();
                    send_frame(1'b0);
                end else if (kind < 64) begin
                    if ($urandom_range(0, 1))
                        build_ack();
                    else
                        build_other();
                    send_frame(1'b1);
                end else if (kind < 69) begin
                    send_wrapping_frame();
                end else if (kind < 72) begin
                    build_status(rand_byte(), rand_byte(), rand_byte(), rand_byte());
                    n = $urandom_range(1, 10);
                    for (int i = 0; i < n; i++) send_byte(frame_bytes[i]);
                end else if (kind < 87) begin
                    send_command(3'($urandom_range(0, int'(CMD_BAD_LAST))));
                end else if (kind < 95) begin
                    send_ticks($urandom_range(1, 2 * int'(poll_period_cfg) + 2));
                end else if (kind < 98) begin
                    send_item(OP_UNUSED, rand_byte(), 3'($urandom_range(0, 7)));
                end else begin
                    send_byte(rand_byte());
                end
            end
        end
        drain_results();
    endtask

    initial begin : run_tests
        for (int i = 0; i < 16; i++) rx_frame[i] = '0;
        rx_index = '0;
        rx_sum = '0;
        rx_len = '0;
        reply_pending = 1'b0;
        linked = 1'b0;
        flags_q = '0;
        status_sum_q = '0;
        nack_q = '0;
        rx_quiet_ms = '0;
        poll_age_ms = '0;
        status_age_ms = '0;
        poll_period_cfg = POLL_PERIOD_RST;
        stall_cfg = STALL_TIMEOUT_RST;
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_in_item = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_values();
        test_commands();
        test_frames();
        test_timing();
        test_back_pressure();
        test_random();

        drain_results();
        repeat (8) @(posedge i_clk);
        if (expected_results.size() != 0)
            flag_mismatch("results never delivered", expected_results.size(), 0);
        if (mismatches == 0)
            $display("[deck_serial_status_link] OK");
        else
            $display("[deck_serial_status_link] ERROR");
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("[deck_serial_status_link] ERROR");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+design
design/dsl_pkg.sv
design/dsl_front.sv
design/dsl_queue.sv
design/dsl_back.sv
design/deck_serial_status_link.sv
design/dsl_checker.sv
tb/deck_serial_status_link_tb.sv
